// File: design/mte_pkg.sv
// ---------------------------------------------------------------------------
// mte_pkg - shared types and constants for the MIDI track event encoder
// Event record, opcode codes, status bytes and frame layout.
// ---------------------------------------------------------------------------
package mte_pkg;

    localparam int unsigned TICK_W      = 32;
    localparam int unsigned FRAME_BYTES = 11;               // worst case: note on
    localparam int unsigned FRAME_W     = FRAME_BYTES * 8;
    localparam int unsigned BODY_BYTES  = 7;
    localparam int unsigned BODY_W      = BODY_BYTES * 8;
    localparam int unsigned VLQ_W       = 32;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned TDATA_IN_W  = 80;

    typedef enum logic [2:0] {
        OP_NOTE_ON  = 3'd0,
        OP_NOTE_OFF = 3'd1,
        OP_BEND     = 3'd2,
        OP_CTRL     = 3'd3,
        OP_EOT      = 3'd4
    } t_opcode;

    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_CTRL     = 8'hB0;
    localparam logic [7:0] ST_BEND     = 8'hE0;
    localparam logic [7:0] META_MARK   = 8'hFF;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] VLQ_MORE    = 8'h80;

    typedef struct packed {
        t_opcode             opcode;
        logic [TICK_W-1:0]   event_tick;
        logic [3:0]          channel;
        logic [6:0]          note_pitch;
        logic [6:0]          note_velocity;
        logic [13:0]         bend_amount;
        logic [6:0]          controller_number;
        logic [6:0]          controller_value;
    } t_event;

    // data: byte 0 (first on the wire) in the lowest bits
    typedef struct packed {
        logic [FRAME_W-1:0]  data;
        logic [CNT_W-1:0]    count;
    } t_frame;

endpackage

// File: design/mte_frame_build.sv
// ---------------------------------------------------------------------------
// mte_frame_build - event to byte frame
// Delta time, saturation, VLQ packing and message body for one event.
// ---------------------------------------------------------------------------
module mte_frame_build (
    input  mte_pkg::t_event              i_event,
    input  logic [mte_pkg::TICK_W-1:0]   i_last_tick,
    output mte_pkg::t_frame              o_frame
);
    import mte_pkg::*;

    logic [TICK_W-1:0] w_delta;
    logic [27:0]       w_sat;
    logic [2:0]        w_nv;
    logic [VLQ_W-1:0]  w_vlq;
    logic [BODY_W-1:0] w_body;
    logic [CNT_W-1:0]  w_body_len;
    logic [7:0]        w_g0, w_g1, w_g2, w_g3;
    logic [7:0]        w_st_bend;

    always_comb begin
        w_delta = (i_event.event_tick >= i_last_tick) ?
                  (i_event.event_tick - i_last_tick) : '0;
        w_sat   = (w_delta[31:28] != 4'd0) ? '1 : w_delta[27:0];
        w_g0    = {1'b0, w_sat[6:0]};
        w_g1    = VLQ_MORE | {1'b0, w_sat[13:7]};
        w_g2    = VLQ_MORE | {1'b0, w_sat[20:14]};
        w_g3    = VLQ_MORE | {1'b0, w_sat[27:21]};

        if (i_event.opcode == OP_EOT) begin
            w_nv  = 3'd1;
            w_vlq = '0;
        end else if (w_sat[27:21] != 7'd0) begin
            w_nv  = 3'd4;
            w_vlq = {w_g0, w_g1, w_g2, w_g3};
        end else if (w_sat[20:14] != 7'd0) begin
            w_nv  = 3'd3;
            w_vlq = {8'd0, w_g0, w_g1, w_g2};
        end else if (w_sat[13:7] != 7'd0) begin
            w_nv  = 3'd2;
            w_vlq = {16'd0, w_g0, w_g1};
        end else begin
            w_nv  = 3'd1;
            w_vlq = {24'd0, w_g0};
        end

        w_st_bend = {ST_BEND[7:4], i_event.channel};
        case (i_event.opcode)
            OP_NOTE_ON: begin
                // bend message, zero delta, then the note on itself
                w_body     = {1'b0, i_event.note_velocity, 1'b0, i_event.note_pitch,
                              ST_NOTE_ON[7:4], i_event.channel, BYTE_ZERO,
                              1'b0, i_event.bend_amount[13:7],
                              1'b0, i_event.bend_amount[6:0], w_st_bend};
                w_body_len = CNT_W'(7);
            end
            OP_NOTE_OFF: begin
                w_body     = {32'd0, BYTE_ZERO, 1'b0, i_event.note_pitch,
                              ST_NOTE_OFF[7:4], i_event.channel};
                w_body_len = CNT_W'(3);
            end
            OP_BEND: begin
                w_body     = {32'd0, 1'b0, i_event.bend_amount[13:7],
                              1'b0, i_event.bend_amount[6:0], w_st_bend};
                w_body_len = CNT_W'(3);
            end
            OP_CTRL: begin
                w_body     = {32'd0, 1'b0, i_event.controller_value,
                              1'b0, i_event.controller_number,
                              ST_CTRL[7:4], i_event.channel};
                w_body_len = CNT_W'(3);
            end
            OP_EOT: begin
                w_body     = {32'd0, BYTE_ZERO, META_EOT, META_MARK};
                w_body_len = CNT_W'(3);
            end
            default: begin
                w_body     = '0;
                w_body_len = '0;
            end
        endcase

        o_frame.data  = ({{(FRAME_W-BODY_W){1'b0}}, w_body} << {w_nv, 3'b000})
                      | {{(FRAME_W-VLQ_W){1'b0}}, w_vlq};
        o_frame.count = {1'b0, w_nv} + w_body_len;
    end

endmodule

// File: design/mte_byte_serializer.sv
// ---------------------------------------------------------------------------
// mte_byte_serializer - frame buffer and output register
// Shifts a frame out one byte per transfer; reloads as the last byte leaves.
// ---------------------------------------------------------------------------
module mte_byte_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_frm_valid,
    input  mte_pkg::t_frame i_frame,
    output logic            o_frm_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last
);
    import mte_pkg::*;

    logic [FRAME_W-1:0] r_data;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;

    logic w_out_free;
    logic w_pop;
    logic w_load;

    assign w_out_free  = !r_out_valid || i_ready;
    assign w_pop       = (r_cnt != '0) && w_out_free;
    assign o_frm_ready = (r_cnt == '0) || (w_pop && (r_cnt == CNT_W'(1)));
    assign w_load      = i_frm_valid && o_frm_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_cnt <= i_frame.count;
            end else if (w_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_frame.data;
        end else if (w_pop) begin
            r_data <= r_data >> 8;
        end
        if (w_pop) begin
            r_out_byte <= r_data[7:0];
            r_out_last <= (r_cnt == CNT_W'(1));
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

// File: design/midi_track_event_encoder.sv
// ---------------------------------------------------------------------------
// midi_track_event_encoder - MIDI track event to byte stream
// Turns time-stamped events into track bytes: VLQ delta time + message.
// ---------------------------------------------------------------------------
//
// Channel    | Dir | tdata                                  | tuser  | tlast
// -----------+-----+----------------------------------------+--------+-----------
// s_axis     | in  | tick, chan, pitch, vel, bend, cc#, ccv | opcode | -
// m_axis     | out | out_byte                               | -      | last_byte
//
// One output byte per cycle while m_axis_tready is high; an event makes 4 to
// 11 bytes (note on is 7 bytes plus a 1..4 byte delta). The byte-wide output
// register sets that rate. Unused opcodes 5..7 are dropped at the input register.
// An event passes the input register, frame buffer and output register in turn.
// Reset (synchronous, active low) empties all stages and clears last_tick.
// The input register and frame buffer keep taking events while the output
// stalls, until both are full.
//
module midi_track_event_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] event_tick, [35:32] channel, [42:36] note_pitch,
    // [49:43] note_velocity, [63:50] bend_amount, [70:64] controller_number,
    // [77:71] controller_value, [79:78] zero
    input  logic [79:0] i_s_axis_tdata,
    // [2:0] opcode
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  o_m_axis_tdata,
    // last_byte
    output logic        o_m_axis_tlast
);
    import mte_pkg::*;

    t_event             r_in;
    logic               r_in_valid;
    logic [TICK_W-1:0]  r_last_tick;

    t_event             w_event;
    t_frame             w_frame;
    logic               w_frm_ready;
    logic               w_s_xfer;
    logic               w_op_ok;
    logic               w_adv;

    // Unpack the slave transfer into the event record.
    always_comb begin
        w_event.opcode            = t_opcode'(i_s_axis_tuser);
        w_event.event_tick        = i_s_axis_tdata[31:0];
        w_event.channel           = i_s_axis_tdata[35:32];
        w_event.note_pitch        = i_s_axis_tdata[42:36];
        w_event.note_velocity     = i_s_axis_tdata[49:43];
        w_event.bend_amount       = i_s_axis_tdata[63:50];
        w_event.controller_number = i_s_axis_tdata[70:64];
        w_event.controller_value  = i_s_axis_tdata[77:71];
    end

    assign w_op_ok = (w_event.opcode == OP_NOTE_ON) || (w_event.opcode == OP_NOTE_OFF) ||
                     (w_event.opcode == OP_BEND)    || (w_event.opcode == OP_CTRL) ||
                     (w_event.opcode == OP_EOT);

    assign o_s_axis_tready = !r_in_valid || w_frm_ready;
    assign w_s_xfer        = i_s_axis_tvalid && o_s_axis_tready;
    // event moves from the input register into the frame buffer
    assign w_adv           = r_in_valid && w_frm_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_last_tick <= '0;
        end else begin
            if (o_s_axis_tready) begin
                // opcodes with no meaning make no bytes: drop them here
                r_in_valid <= w_s_xfer && w_op_ok;
            end
            // end of track carries no timing and leaves last_tick alone
            if (w_adv && (r_in.opcode != OP_EOT)) begin
                r_last_tick <= r_in.event_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_in <= w_event;
        end
    end

    mte_frame_build u_build (
        .i_event     (r_in),
        .i_last_tick (r_last_tick),
        .o_frame     (w_frame)
    );

    mte_byte_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frm_valid (r_in_valid),
        .i_frame     (w_frame),
        .o_frm_ready (w_frm_ready),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

    // An event waiting on a busy frame buffer stays put.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_frm_ready |=> r_in_valid)
        else $error("input stage lost an event while the frame buffer was busy");

    // last_tick moves only when a timed event enters the frame buffer.
    a_tick_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_adv && (r_in.opcode != OP_EOT)) |=> $stable(r_last_tick))
        else $error("last_tick changed without a timed event");

    // Every frame built is between 4 and 11 bytes.
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (w_frame.count >= CNT_W'(4)) && (w_frame.count <= CNT_W'(FRAME_BYTES)))
        else $error("frame length out of range");

    // Back-pressure toward the source only comes from a held event.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid)
        else $error("tready low with an empty input stage");

endmodule
